// ===== rtl/mrp_pkg.sv =====
`default_nettype none

package mrp_pkg;

  // Item fields
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned PIN_W    = 6;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned LEVELS_W = 5;
  localparam int unsigned STATUS_W = 2;

  // Input word layout, lowest bit first: pin, range_min, range_max, duty
  localparam int unsigned PIN_LSB   = 0;
  localparam int unsigned RMIN_LSB  = PIN_LSB + PIN_W;
  localparam int unsigned RMAX_LSB  = RMIN_LSB + VAL_W;
  localparam int unsigned DUTY_LSB  = RMAX_LSB + VAL_W;
  localparam int unsigned IN_BITS   = DUTY_LSB + VAL_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output word layout, lowest bit first: levels, status
  localparam int unsigned OUT_BITS   = LEVELS_W + STATUS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Duty loaded by a channel init, before clamping to the range
  localparam logic [VAL_W-1:0] INIT_DUTY = 16'd10;

  // Divider steps: one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = $clog2(LEN_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_INIT = 2'd1,
    FUNC_SET  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_UNKNOWN_PIN = 2'd1,
    ST_TABLE_FULL  = 2'd2,
    ST_BAD_RANGE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_TICK_CHK,
    S_MUL_A,
    S_MUL_B,
    S_LOAD,
    S_SET_SCAN,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    rem_dec;
    logic    init_write;
    logic    want_flip;
    logic    div_step;
    logic    mul_a;
    logic    mul_b;
    logic    load_phase;
    logic    count_inc;
    logic    set_duty;
    logic    code_we;
    status_t code;
    logic    emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  bad_range;
    logic  last;
    logic  rem_gt1;
    logic  pin_match;
    logic  div_done;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/mrp_ctrl.sv =====
`default_nettype none

module mrp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire mrp_pkg::sts_t sts,
  output mrp_pkg::cmd_t      cmd
);

  mrp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = mrp_pkg::ST_OK;
    in_tready = 1'b0;
    case (state_r)
      mrp_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = mrp_pkg::S_DECODE;
        end
      end
      mrp_pkg::S_DECODE: begin
        cmd.code_we = 1'b1;
        case (sts.func)
          mrp_pkg::FUNC_TICK: begin
            if (sts.empty) begin
              state_nxt = mrp_pkg::S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = mrp_pkg::S_TICK_CHK;
            end
          end
          mrp_pkg::FUNC_INIT: begin
            if (sts.full) begin
              cmd.code  = mrp_pkg::ST_TABLE_FULL;
              state_nxt = mrp_pkg::S_EMIT;
            end else if (sts.bad_range) begin
              cmd.code  = mrp_pkg::ST_BAD_RANGE;
              state_nxt = mrp_pkg::S_EMIT;
            end else begin
              cmd.init_write = 1'b1;
              state_nxt      = mrp_pkg::S_DIV;
            end
          end
          mrp_pkg::FUNC_SET: begin
            // Assume a miss until the scan finds the pin
            cmd.code = mrp_pkg::ST_UNKNOWN_PIN;
            if (sts.empty) begin
              state_nxt = mrp_pkg::S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = mrp_pkg::S_SET_SCAN;
            end
          end
          default: begin
            state_nxt = mrp_pkg::S_EMIT;
          end
        endcase
      end
      mrp_pkg::S_SET_SCAN: begin
        if (sts.pin_match) begin
          cmd.set_duty = 1'b1;
          cmd.code_we  = 1'b1;
          state_nxt    = mrp_pkg::S_EMIT;
        end else if (sts.last) begin
          state_nxt = mrp_pkg::S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      mrp_pkg::S_TICK_CHK: begin
        if (sts.rem_gt1) begin
          cmd.rem_dec = 1'b1;
          if (sts.last) begin
            state_nxt = mrp_pkg::S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          cmd.want_flip = 1'b1;
          state_nxt     = mrp_pkg::S_MUL_A;
        end
      end
      mrp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = mrp_pkg::S_MUL_A;
        end
      end
      mrp_pkg::S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = mrp_pkg::S_MUL_B;
      end
      mrp_pkg::S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = mrp_pkg::S_LOAD;
      end
      mrp_pkg::S_LOAD: begin
        cmd.load_phase = 1'b1;
        if (sts.func == mrp_pkg::FUNC_INIT) begin
          cmd.count_inc = 1'b1;
          state_nxt     = mrp_pkg::S_EMIT;
        end else if (sts.last) begin
          state_nxt = mrp_pkg::S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = mrp_pkg::S_TICK_CHK;
        end
      end
      mrp_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mrp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mrp_datapath.sv =====
`default_nettype none

module mrp_datapath #(
  parameter int unsigned CHANNELS     = 5,
  parameter logic [31:0] PERIOD_TICKS = 32'd1000000
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mrp_pkg::cmd_t                      cmd,
  output mrp_pkg::sts_t                           sts,
  input  wire logic [mrp_pkg::FUNC_W-1:0]         in_tuser,
  input  wire logic [mrp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [mrp_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam int unsigned PAD_W =
    (CHANNELS > mrp_pkg::LEVELS_W) ? CHANNELS : mrp_pkg::LEVELS_W;
  localparam int unsigned VW = mrp_pkg::VAL_W;
  localparam int unsigned LW = mrp_pkg::LEN_W;

  // Captured item
  mrp_pkg::func_t        func_r;
  logic [mrp_pkg::PIN_W-1:0] pin_r;
  logic [VW-1:0]         rmin_r;
  logic [VW-1:0]         rmax_r;
  logic [VW-1:0]         duty_r;

  // Channel table
  logic [mrp_pkg::PIN_W-1:0] chan_pin_r   [CHANNELS];
  logic [VW-1:0]             chan_range_r [CHANNELS];
  logic [LW-1:0]             chan_step_r  [CHANNELS];
  logic [VW-1:0]             chan_duty_r  [CHANNELS];
  logic [LW-1:0]             chan_rem_r   [CHANNELS];
  logic [CHANNELS-1:0]       chan_high_r;
  logic [CNT_W-1:0]          count_r;

  // Sequencing and arithmetic
  logic [IDX_W-1:0]               idx_r;
  logic                           want_r;
  logic [LW-1:0]                  len_a_r;
  logic [LW-1:0]                  len_b_r;
  logic [LW-1:0]                  div_q_r;
  logic [VW-1:0]                  div_part_r;
  logic [mrp_pkg::DIV_CNT_W-1:0]  div_cnt_r;
  mrp_pkg::status_t               code_r;

  // Result register
  logic                              out_valid_r;
  logic [mrp_pkg::LEVELS_W-1:0]      out_levels_r;
  mrp_pkg::status_t                  out_status_r;

  logic [VW-1:0]   range_new;
  logic [VW-1:0]   init_duty;
  logic [IDX_W-1:0] new_idx;
  logic [mrp_pkg::PIN_W-1:0] cur_pin;
  logic [VW-1:0]   cur_range;
  logic [VW-1:0]   cur_duty;
  logic [LW-1:0]   cur_step;
  logic [LW-1:0]   cur_rem;
  logic            cur_high;
  logic [VW-1:0]   set_duty_val;
  logic            mul_sel_high;
  logic [VW-1:0]   mul_n;
  logic [LW+VW-1:0] mul_p;
  logic [VW:0]     div_shift;
  logic [VW:0]     div_diff;
  logic            div_ge;
  logic [VW-1:0]   div_part_nxt;
  logic [LW-1:0]   div_q_nxt;
  logic            load_high;
  logic [LW-1:0]   load_len;
  logic [PAD_W-1:0] high_pad;

  assign range_new = rmax_r - rmin_r;
  assign init_duty = (mrp_pkg::INIT_DUTY < range_new) ? mrp_pkg::INIT_DUTY : range_new;
  assign new_idx   = IDX_W'(count_r);

  assign cur_pin   = chan_pin_r[idx_r];
  assign cur_range = chan_range_r[idx_r];
  assign cur_duty  = chan_duty_r[idx_r];
  assign cur_step  = chan_step_r[idx_r];
  assign cur_rem   = chan_rem_r[idx_r];
  assign cur_high  = chan_high_r[idx_r];

  assign set_duty_val = (duty_r < cur_range) ? duty_r : cur_range;

  // Shared multiplier: first pass the wanted phase, second pass the opposite one
  assign mul_sel_high = cmd.mul_a ? want_r : !want_r;
  assign mul_n        = mul_sel_high ? cur_duty : (cur_range - cur_duty);
  assign mul_p        = (LW + VW)'(cur_step) * (LW + VW)'(mul_n);

  // Restoring divider, one quotient bit a cycle
  assign div_shift    = {div_part_r, div_q_r[LW-1]};
  assign div_ge       = (div_shift >= {1'b0, cur_range});
  assign div_diff     = div_shift - {1'b0, cur_range};
  assign div_part_nxt = div_ge ? div_diff[VW-1:0] : div_shift[VW-1:0];
  assign div_q_nxt    = {div_q_r[LW-2:0], div_ge};

  // Skip a zero-length phase; both zero parks the channel low
  always_comb begin
    if (len_a_r != '0) begin
      load_high = want_r;
      load_len  = len_a_r;
    end else if (len_b_r != '0) begin
      load_high = !want_r;
      load_len  = len_b_r;
    end else begin
      load_high = 1'b0;
      load_len  = '0;
    end
  end

  assign high_pad = PAD_W'(chan_high_r);

  always_comb begin
    sts           = '0;
    sts.func      = func_r;
    sts.empty     = (count_r == '0);
    sts.full      = (count_r == CNT_W'(CHANNELS));
    sts.bad_range = (rmax_r <= rmin_r);
    sts.last      = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    sts.rem_gt1   = (cur_rem > LW'(1));
    sts.pin_match = (cur_pin == pin_r);
    sts.div_done  = (div_cnt_r == mrp_pkg::DIV_CNT_W'(LW - 1));
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      chan_high_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.load_phase) begin
        chan_high_r[idx_r] <= load_high;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= mrp_pkg::func_t'(in_tuser);
      pin_r  <= in_tdata[mrp_pkg::PIN_LSB +: mrp_pkg::PIN_W];
      rmin_r <= in_tdata[mrp_pkg::RMIN_LSB +: VW];
      rmax_r <= in_tdata[mrp_pkg::RMAX_LSB +: VW];
      duty_r <= in_tdata[mrp_pkg::DUTY_LSB +: VW];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end else if (cmd.init_write) begin
      idx_r <= new_idx;
    end
    if (cmd.init_write) begin
      chan_pin_r[new_idx]   <= pin_r;
      chan_range_r[new_idx] <= range_new;
      chan_duty_r[new_idx]  <= init_duty;
      want_r                <= 1'b1;
      div_q_r               <= PERIOD_TICKS;
      div_part_r            <= '0;
      div_cnt_r             <= '0;
    end
    if (cmd.want_flip) begin
      want_r <= !cur_high;
    end
    if (cmd.div_step) begin
      div_q_r    <= div_q_nxt;
      div_part_r <= div_part_nxt;
      div_cnt_r  <= div_cnt_r + mrp_pkg::DIV_CNT_W'(1);
      if (sts.div_done) begin
        chan_step_r[idx_r] <= div_q_nxt;
      end
    end
    if (cmd.mul_a) begin
      len_a_r <= mul_p[LW-1:0];
    end
    if (cmd.mul_b) begin
      len_b_r <= mul_p[LW-1:0];
    end
    if (cmd.rem_dec) begin
      chan_rem_r[idx_r] <= cur_rem - LW'(1);
    end
    if (cmd.load_phase) begin
      chan_rem_r[idx_r] <= load_len;
    end
    if (cmd.set_duty) begin
      chan_duty_r[idx_r] <= set_duty_val;
    end
    if (cmd.code_we) begin
      code_r <= cmd.code;
    end
    if (cmd.emit) begin
      out_levels_r <= high_pad[mrp_pkg::LEVELS_W-1:0];
      out_status_r <= code_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mrp_pkg::OUT_DATA_W'({out_status_r, out_levels_r});

endmodule

`default_nettype wire

// ===== rtl/multichannel_range_pwm.sv =====
`default_nettype none
// Sequence: a tick walks the slots, counting each down or reloading a phase by multiply and load;
//   an init runs the one-bit-per-cycle step divider, then multiply and load; a set scans the slots.
// Throughput: one word at a time; the next input word is taken the cycle after a result is
//   registered, while that result may still wait on the output side.
// Reset: rst_n synchronous, active low; clears the channel count, phase levels, output valid
//   and the controller; no clearing pass, the table is written by init before it is read.

module multichannel_range_pwm #(
  parameter int unsigned CHANNELS     = 5,        // channel slots, 1 to 32
  parameter logic [31:0] PERIOD_TICKS = 32'd1000000
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [mrp_pkg::FUNC_W-1:0]    in_tuser,   // func
  input  wire logic [mrp_pkg::IN_DATA_W-1:0] in_tdata,   // pin, range_min, range_max, duty
  // Result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [mrp_pkg::OUT_DATA_W-1:0]     out_tdata   // levels, status
);

  // Command and status between the sequencer and the channel table
  mrp_pkg::cmd_t cmd;
  mrp_pkg::sts_t sts;

  // Sequencer: decodes the word, walks the slots, runs divide and multiply steps
  mrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Channel table, divider, shared multiplier and result register
  mrp_datapath #(
    .CHANNELS     (CHANNELS),
    .PERIOD_TICKS (PERIOD_TICKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== verif/multichannel_range_pwm_test.sv =====
`timescale 1ns / 1ps

module multichannel_range_pwm_test;
  import mrp_pkg::*;

  localparam int unsigned CHAN         = 5;
  localparam logic [31:0] PERIOD       = 32'd1000000;
  localparam int          RANDOM_WORDS = 1627;
  localparam int          CYCLE_LIMIT  = 1000000;
  // Give a wide margin at the end, past the longest tick or init
  localparam int          SETTLE_CYCLES = 80;

  // One input word as the stimulus sees it; drain holds the word back until the
  // block has handed out every pending result
  typedef struct packed {
    func_t            func;
    logic [PIN_W-1:0] pin;
    logic [VAL_W-1:0] rmin;
    logic [VAL_W-1:0] rmax;
    logic [VAL_W-1:0] duty;
    logic             drain;
  } pwm_word_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] levels;
    status_t             status;
  } pwm_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [FUNC_W-1:0]     in_tuser  = '0;   // func
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // pin, range_min, range_max, duty
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // levels, status

  multichannel_range_pwm #(
    .CHANNELS    (CHAN),
    .PERIOD_TICKS(PERIOD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Channel table predictor: own copy of the slot state
  // ---------------------------------------------------------------------------
  logic [PIN_W-1:0] slot_pin   [CHAN] = '{default: '0};
  logic [VAL_W-1:0] slot_range [CHAN] = '{default: '0};
  logic [LEN_W-1:0] slot_step  [CHAN] = '{default: '0};
  logic [VAL_W-1:0] slot_duty  [CHAN] = '{default: '0};
  logic             slot_high  [CHAN] = '{default: 1'b0};
  logic [LEN_W-1:0] slot_left  [CHAN] = '{default: '0};
  int               slots_used = 0;

  // Length in ticks of the high or low phase of one slot at its current duty
  function automatic logic [LEN_W-1:0] phase_ticks(int s, logic hi);
    logic [31:0] n;
    logic [63:0] p;
    n = hi ? 32'(slot_duty[s]) : 32'(slot_range[s]) - 32'(slot_duty[s]);
    p = 64'(slot_step[s]) * 64'(n);
    return p[LEN_W-1:0];
  endfunction

  // Load a phase; skip to the opposite one when it is empty, park low when both are
  function automatic void start_phase(int s, logic hi);
    logic             h;
    logic [LEN_W-1:0] len;
    h   = hi;
    len = phase_ticks(s, h);
    if (len == '0) begin
      h   = !h;
      len = phase_ticks(s, h);
    end
    slot_high[s] = (len == '0) ? 1'b0 : h;
    slot_left[s] = len;
  endfunction

  task automatic apply_pwm_word(input pwm_word_t w, output pwm_result_t r);
    int               s;
    logic             found;
    logic [VAL_W-1:0] span;
    r.status = ST_OK;
    r.levels = '0;
    found    = 1'b0;
    case (w.func)
      FUNC_TICK: begin
        for (s = 0; s < slots_used; s++) begin
          if (slot_left[s] > 32'd1) slot_left[s] = slot_left[s] - 32'd1;
          else start_phase(s, !slot_high[s]);
        end
      end
      FUNC_INIT: begin
        // A full table wins over a bad range
        if (slots_used >= CHAN) begin
          r.status = ST_TABLE_FULL;
        end else if (w.rmax <= w.rmin) begin
          r.status = ST_BAD_RANGE;
        end else begin
          span                   = w.rmax - w.rmin;
          slot_pin[slots_used]   = w.pin;
          slot_range[slots_used] = span;
          slot_step[slots_used]  = PERIOD / 32'(span);
          slot_duty[slots_used]  = (INIT_DUTY < span) ? INIT_DUTY : span;
          start_phase(slots_used, 1'b1);
          slots_used++;
        end
      end
      FUNC_SET: begin
        // Only the lowest slot holding the pin takes the new duty
        for (s = 0; s < slots_used; s++) begin
          if (!found && slot_pin[s] == w.pin) begin
            slot_duty[s] = (w.duty < slot_range[s]) ? w.duty : slot_range[s];
            found        = 1'b1;
          end
        end
        if (!found) r.status = ST_UNKNOWN_PIN;
      end
      default: ;
    endcase
    for (s = 0; s < slots_used; s++) r.levels[s] = slot_high[s];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus store, expected results, bookkeeping
  // ---------------------------------------------------------------------------
  pwm_word_t   pending_words[$];
  pwm_result_t expected_levels[$];
  pwm_word_t   cur_word;
  logic        in_took     = 1'b0;
  logic        out_took    = 1'b0;
  int          words_taken = 0;
  int          results_seen = 0;
  int          fail_count  = 0;
  int          cycle_n     = 0;
  int          idle_left   = 0;
  int          sent_n      = 0;
  int          stall_left  = 0;
  int          hold_left   = 0;

  // Predict on every accepted input word, check every accepted result word
  always @(posedge clk) begin : track_words
    pwm_result_t e;
    pwm_result_t got;
    in_took  <= in_tvalid && in_tready;
    out_took <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      apply_pwm_word(cur_word, e);
      expected_levels.push_back(e);
      words_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.levels = out_tdata[LEVELS_W-1:0];
      got.status = status_t'(out_tdata[LEVELS_W +: STATUS_W]);
      results_seen++;
      if (expected_levels.size() == 0) begin
        $error("result word with nothing expected: levels %0h status %0d",
               got.levels, got.status);
        fail_count++;
      end else begin
        e = expected_levels.pop_front();
        if (got.levels !== e.levels) begin
          $error("levels: expected %0h, actual %0h", e.levels, got.levels);
          fail_count++;
        end
        if (got.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, got.status);
          fail_count++;
        end
      end
    end
  end

  // Driver: offer the next pending word after its idle gap; hold a drain word
  // back until all results are in
  always @(negedge clk) begin : drive_words
    pwm_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (idle_left > 0) begin
        idle_left--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain && expected_levels.size() != 0)) begin
        w = pending_words.pop_front();
        cur_word  <= w;
        in_tuser  <= w.func;
        in_tdata  <= IN_DATA_W'({w.duty, w.rmax, w.rmin, w.pin});
        in_tvalid <= 1'b1;
        sent_n++;
        // Every fourth stretch of words runs back to back
        idle_left = ((sent_n % 400) >= 300) ? 0 : $urandom_range(0, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a random gap after results outside some stretches, and once hold off long enough to back
  // the block up into its input
  always @(negedge clk) begin : accept_results
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took) begin
        stall_left = ((results_seen % 300) >= 220) ? 0 : $urandom_range(0, 14);
        if (results_seen == 600) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("multichannel_range_pwm_test NOT OK");
      $finish;
    end
  end

  task automatic queue_word(input func_t f, input logic [PIN_W-1:0] p,
                            input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
                            input logic [VAL_W-1:0] d);
    pwm_word_t w;
    w.func  = f;
    w.pin   = p;
    w.rmin  = lo;
    w.rmax  = hi;
    w.duty  = d;
    w.drain = 1'b0;
    pending_words.push_back(w);
  endtask

  initial begin : run
    logic [PIN_W-1:0] known_pins [4];
    pwm_word_t        w;
    int               n;
    int               pick;
    int               total;
    known_pins = '{6'd0, 6'd63, 6'd42, 6'd21};

    // Directed: empty table, bad ranges, clamps, duplicate pin, full table
    queue_word(FUNC_SET,  6'd5,  16'd0,     16'd0,     16'd3);      // unknown pin, empty
    queue_word(FUNC_TICK, 6'd0,  16'd0,     16'd0,     16'd0);      // tick, no slots
    queue_word(FUNC_NOP,  6'd63, 16'hFFFF,  16'hFFFF,  16'hFFFF);
    queue_word(FUNC_INIT, 6'd0,  16'd100,   16'd100,   16'd0);      // equal ends
    queue_word(FUNC_INIT, 6'd63, 16'hFFFF,  16'd0,     16'd0);      // reversed ends
    queue_word(FUNC_INIT, 6'd0,  16'd0,     16'hFFFF,  16'd0);      // widest range
    queue_word(FUNC_TICK, 6'd0,  16'd0,     16'd0,     16'd0);
    queue_word(FUNC_INIT, 6'd63, 16'hFFFE,  16'hFFFF,  16'd0);      // range 1, duty clamps
    queue_word(FUNC_INIT, 6'd0,  16'd0,     16'd4,     16'd0);      // duplicate pin
    queue_word(FUNC_SET,  6'd0,  16'd0,     16'd0,     16'hFFFF);   // lowest slot only
    queue_word(FUNC_SET,  6'd63, 16'd0,     16'd0,     16'hFFFF);   // clamp to range
    queue_word(FUNC_SET,  6'd17, 16'd0,     16'd0,     16'd0);      // unknown pin
    queue_word(FUNC_TICK, 6'd0,  16'd0,     16'd0,     16'd0);
    queue_word(FUNC_INIT, 6'd42, 16'd1,     16'd3,     16'd0);
    queue_word(FUNC_INIT, 6'd21, 16'd24000, 16'd25000, 16'd0);      // fills the table
    queue_word(FUNC_INIT, 6'd5,  16'd0,     16'hFFFF,  16'd0);      // table full
    queue_word(FUNC_INIT, 6'd5,  16'd9,     16'd9,     16'd0);      // full beats bad range
    queue_word(FUNC_SET,  6'd42, 16'd0,     16'd0,     16'd0);      // duty zero
    queue_word(FUNC_SET,  6'd0,  16'd0,     16'd0,     16'd1);
    queue_word(FUNC_TICK, 6'd0,  16'd0,     16'd0,     16'd0);
    queue_word(FUNC_NOP,  6'd0,  16'd0,     16'd0,     16'd0);
    queue_word(FUNC_SET,  6'd21, 16'd0,     16'd0,     16'd0);
    queue_word(FUNC_TICK, 6'd63, 16'hFFFF,  16'hFFFF,  16'hFFFF);

    // Random: mostly ticks and sets on live pins, some noise inits and no-ops
    for (n = 0; n < RANDOM_WORDS; n++) begin
      w.func  = FUNC_TICK;
      w.pin   = PIN_W'($urandom);
      w.rmin  = VAL_W'($urandom);
      w.rmax  = VAL_W'($urandom);
      w.duty  = VAL_W'($urandom);
      w.drain = (n == 900);
      pick    = $urandom_range(0, 99);
      if (pick < 68) begin
        w.func = FUNC_TICK;
      end else if (pick < 90) begin
        w.func = FUNC_SET;
        if ($urandom_range(0, 4) != 0) w.pin = known_pins[$urandom_range(0, 3)];
        case ($urandom_range(0, 3))
          0: w.duty = VAL_W'($urandom_range(0, 4));
          1: w.duty = 16'hFFFF - VAL_W'($urandom_range(0, 4));
          2: w.duty = VAL_W'($urandom_range(0, 1200));
          default: ;
        endcase
      end else if (pick < 95) begin
        w.func = FUNC_INIT;
      end else begin
        w.func = FUNC_NOP;
      end
      pending_words.push_back(w);
    end
    total = pending_words.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (words_taken == total && expected_levels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("multichannel_range_pwm_test OK");
    end else begin
      $display("multichannel_range_pwm_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mrp_pkg.sv
rtl/mrp_ctrl.sv
rtl/mrp_datapath.sv
rtl/multichannel_range_pwm.sv
verif/multichannel_range_pwm_test.sv
